/* rtl/core/hcb_pkg.sv */
`timescale 1ns / 1ps

package hcb_pkg;

  // Default sizes
  localparam int SymbolsDef   = 128;
  localparam int CountBitsDef = 16;
  localparam int MaxCodeDef   = 48;

  // Requested operation
  typedef enum logic [1:0] {
    ACT_ADD   = 2'd0,
    ACT_BUILD = 2'd1,
    ACT_QUERY = 2'd2,
    ACT_CLEAR = 2'd3
  } action_e;

  // Result status
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_ABSENT = 2'd1,
    ST_NOTREE = 2'd2,
    ST_EMPTY  = 2'd3
  } status_e;

  // Sequencer states, one-hot
  typedef enum logic [11:0] {
    S_IDLE  = 12'b0000_0000_0001,
    S_ADD   = 12'b0000_0000_0010,
    S_LEAF  = 12'b0000_0000_0100,
    S_SCAN  = 12'b0000_0000_1000,
    S_WTOP  = 12'b0000_0001_0000,
    S_WA    = 12'b0000_0010_0000,
    S_WB    = 12'b0000_0100_0000,
    S_QSYM  = 12'b0000_1000_0000,
    S_QWALK = 12'b0001_0000_0000,
    S_RESP  = 12'b0010_0000_0000,
    S_SPARE = 12'b0100_0000_0000,
    S_TRAP  = 12'b1000_0000_0000
  } state_e;

endpackage

/* rtl/core/hcb_ram.sv */
`timescale 1ns / 1ps

module hcb_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/hcb_engine.sv */
`timescale 1ns / 1ps

module hcb_engine #(
  parameter int Symbols   = 128,
  parameter int CountBits = 16,
  parameter int MaxCode   = 48
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  input  logic [1:0]                         action_i,
  input  logic [6:0]                         symbol_i,
  output logic                               ready_o,
  input  logic                               out_free_i,
  output logic                               res_valid_o,
  output hcb_pkg::status_e                   res_status_o,
  output logic [$clog2(Symbols+1)-1:0]       res_count_o,
  output logic [$clog2(MaxCode+1)-1:0]       res_len_o,
  output logic [MaxCode-1:0]                 res_bits_o
);
  import hcb_pkg::*;

  localparam int SymW    = $clog2(Symbols);
  localparam int Nodes   = 2 * Symbols - 1;
  localparam int NodeW   = $clog2(Nodes);
  localparam int CntW    = $clog2(Symbols + 1);
  localparam int WeightW = CountBits + SymW;
  localparam int RecW    = WeightW + NodeW + 2;
  localparam int DepW    = $clog2(Nodes + 1);
  localparam int LenW    = $clog2(MaxCode + 1);

  state_e state_q, state_d;
  logic [Symbols-1:0] hv_q, hv_d;
  logic tree_q, tree_d;
  logic [CntW-1:0] lt_q, lt_d;
  logic pend_q, pend_d;

  logic [CntW-1:0] sidx_q, sidx_d;
  logic [SymW-1:0] psym_q, psym_d, hidx_q, hidx_d;
  logic [CntW-1:0] nleaf_q, nleaf_d;
  logic [NodeW-1:0] top_q, top_d, j_q, j_d, pj_q, pj_d, a_q, a_d, b_q, b_d;
  logic [WeightW-1:0] wa_q, wa_d, wb_q, wb_d;
  logic va_q, va_d, vb_q, vb_d;
  logic [DepW-1:0] dep_q, dep_d;
  logic [MaxCode-1:0] acc_q, acc_d, bits_q, bits_d;
  logic [LenW-1:0] len_q, len_d;
  status_e st_q, st_d;

  // memory ports
  logic h_we;
  logic [SymW-1:0] h_waddr, h_raddr;
  logic [CountBits-1:0] h_wdata, h_rdata;
  logic n_we;
  logic [NodeW-1:0] n_waddr, n_raddr;
  logic [RecW-1:0] n_wdata, n_rdata;
  logic s_we;
  logic [SymW-1:0] s_waddr, s_raddr;
  logic [NodeW:0] s_wdata, s_rdata;

  logic sym_ok;
  logic [SymW-1:0] sym_idx;
  logic [CountBits-1:0] add_cur, leaf_cur;
  logic [WeightW-1:0] n_w;
  logic [NodeW-1:0] n_par;
  logic n_hp, n_ir;
  action_e act;

  hcb_ram #(.Width(CountBits), .Depth(Symbols)) u_hist (
    .clk_i, .we_i(h_we), .waddr_i(h_waddr), .wdata_i(h_wdata),
    .raddr_i(h_raddr), .rdata_o(h_rdata)
  );

  hcb_ram #(.Width(RecW), .Depth(Nodes)) u_node (
    .clk_i, .we_i(n_we), .waddr_i(n_waddr), .wdata_i(n_wdata),
    .raddr_i(n_raddr), .rdata_o(n_rdata)
  );

  hcb_ram #(.Width(NodeW + 1), .Depth(Symbols)) u_sym (
    .clk_i, .we_i(s_we), .waddr_i(s_waddr), .wdata_i(s_wdata),
    .raddr_i(s_raddr), .rdata_o(s_rdata)
  );

  assign act     = action_e'(action_i);
  assign sym_ok  = int'(symbol_i) < Symbols;
  assign sym_idx = SymW'(symbol_i);

  // counts that were never written since a clear read as zero
  assign add_cur  = hv_q[hidx_q] ? h_rdata : '0;
  assign leaf_cur = hv_q[psym_q] ? h_rdata : '0;

  // node record: {weight, parent, has_parent, is_right}
  assign n_w   = n_rdata[RecW-1 -: WeightW];
  assign n_par = n_rdata[NodeW+1:2];
  assign n_hp  = n_rdata[1];
  assign n_ir  = n_rdata[0];

  assign ready_o      = (state_q == S_IDLE);
  assign res_status_o = st_q;
  assign res_count_o  = lt_q;
  assign res_len_o    = len_q;
  assign res_bits_o   = bits_q;

  // sequencer
  always_comb begin
    state_d = state_q;
    hv_d = hv_q; tree_d = tree_q; lt_d = lt_q; pend_d = pend_q;
    sidx_d = sidx_q; psym_d = psym_q; hidx_d = hidx_q; nleaf_d = nleaf_q;
    top_d = top_q; j_d = j_q; pj_d = pj_q; a_d = a_q; b_d = b_q;
    wa_d = wa_q; wb_d = wb_q; va_d = va_q; vb_d = vb_q;
    dep_d = dep_q; acc_d = acc_q; bits_d = bits_q; len_d = len_q; st_d = st_q;
    h_we = 1'b0; h_waddr = hidx_q; h_wdata = add_cur + 1'b1; h_raddr = sym_idx;
    n_we = 1'b0; n_waddr = top_q; n_wdata = '0; n_raddr = j_q;
    s_we = 1'b0; s_waddr = psym_q; s_wdata = '0; s_raddr = sym_idx;
    res_valid_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          len_d = '0;
          bits_d = '0;
          st_d = ST_OK;
          case (act)
            ACT_ADD: begin
              if (sym_ok) begin
                hidx_d = sym_idx;
                state_d = S_ADD;
              end else begin
                st_d = ST_ABSENT;
                state_d = S_RESP;
              end
            end
            ACT_BUILD: begin
              sidx_d = '0;
              pend_d = 1'b0;
              nleaf_d = '0;
              tree_d = 1'b0;
              state_d = S_LEAF;
            end
            ACT_QUERY: begin
              if (!tree_q) begin
                st_d = ST_NOTREE;
                state_d = S_RESP;
              end else if (!sym_ok) begin
                st_d = ST_ABSENT;
                state_d = S_RESP;
              end else begin
                state_d = S_QSYM;
              end
            end
            ACT_CLEAR: begin
              hv_d = '0;
              state_d = S_RESP;
            end
            default: state_d = S_RESP;
          endcase
        end
      end
      // saturating increment
      S_ADD: begin
        if (add_cur != {CountBits{1'b1}}) begin
          h_we = 1'b1;
          hv_d[hidx_q] = 1'b1;
        end
        state_d = S_RESP;
      end
      // sweep histogram, number the leaves
      S_LEAF: begin
        h_raddr = sidx_q[SymW-1:0];
        pend_d = (sidx_q != CntW'(Symbols));
        psym_d = sidx_q[SymW-1:0];
        if (sidx_q != CntW'(Symbols)) begin
          sidx_d = sidx_q + 1'b1;
        end
        if (pend_q) begin
          s_we = 1'b1;
          s_wdata = {leaf_cur != '0, NodeW'(nleaf_q)};
          if (leaf_cur != '0) begin
            n_we = 1'b1;
            n_waddr = NodeW'(nleaf_q);
            n_wdata = {WeightW'(leaf_cur), NodeW'(0), 1'b0, 1'b0};
            nleaf_d = nleaf_q + 1'b1;
          end
        end else if (sidx_q == CntW'(Symbols)) begin
          lt_d = nleaf_q;
          if (nleaf_q == '0) begin
            st_d = ST_EMPTY;
            state_d = S_RESP;
          end else if (nleaf_q == CntW'(1)) begin
            tree_d = 1'b1;
            state_d = S_RESP;
          end else begin
            top_d = NodeW'(nleaf_q);
            j_d = '0;
            va_d = 1'b0;
            vb_d = 1'b0;
            state_d = S_SCAN;
          end
        end
      end
      // find the two lightest parentless nodes
      S_SCAN: begin
        n_raddr = j_q;
        pend_d = (j_q != top_q);
        pj_d = j_q;
        if (j_q != top_q) begin
          j_d = j_q + 1'b1;
        end
        if (pend_q) begin
          if (!n_hp) begin
            if (!va_q || n_w < wa_q) begin
              b_d = a_q; wb_d = wa_q; vb_d = va_q;
              a_d = pj_q; wa_d = n_w; va_d = 1'b1;
            end else if (!vb_q || n_w < wb_q) begin
              b_d = pj_q; wb_d = n_w; vb_d = 1'b1;
            end
          end
        end else if (j_q == top_q) begin
          state_d = S_WTOP;
        end
      end
      S_WTOP: begin
        n_we = 1'b1;
        n_waddr = top_q;
        n_wdata = {wa_q + wb_q, NodeW'(0), 1'b0, 1'b0};
        state_d = S_WA;
      end
      S_WA: begin
        n_we = 1'b1;
        n_waddr = a_q;
        n_wdata = {wa_q, top_q, 1'b1, 1'b0};
        state_d = S_WB;
      end
      S_WB: begin
        n_we = 1'b1;
        n_waddr = b_q;
        n_wdata = {wb_q, top_q, 1'b1, 1'b1};
        top_d = top_q + 1'b1;
        if (int'(top_q) + 1 == 2 * int'(nleaf_q) - 1) begin
          tree_d = 1'b1;
          state_d = S_RESP;
        end else begin
          j_d = '0;
          pend_d = 1'b0;
          va_d = 1'b0;
          vb_d = 1'b0;
          state_d = S_SCAN;
        end
      end
      // symbol to leaf
      S_QSYM: begin
        if (!s_rdata[NodeW]) begin
          st_d = ST_ABSENT;
          state_d = S_RESP;
        end else begin
          n_raddr = s_rdata[NodeW-1:0];
          dep_d = '0;
          acc_d = '0;
          state_d = S_QWALK;
        end
      end
      // climb to the root, one node per cycle
      S_QWALK: begin
        if (n_hp && dep_q != DepW'(Nodes)) begin
          n_raddr = n_par;
          dep_d = dep_q + 1'b1;
          if (int'(dep_q) < MaxCode) begin
            for (int k = 0; k < MaxCode; k++) begin
              if (int'(dep_q) == k) acc_d[k] = n_ir;
            end
          end else begin
            acc_d = {n_ir, acc_q[MaxCode-1:1]};
          end
        end else begin
          len_d = (int'(dep_q) > MaxCode) ? LenW'(MaxCode) : LenW'(dep_q);
          bits_d = acc_q;
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        if (out_free_i) begin
          res_valid_o = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      hv_q <= '0;
      tree_q <= 1'b0;
      lt_q <= '0;
      pend_q <= 1'b0;
    end else begin
      state_q <= state_d;
      hv_q <= hv_d;
      tree_q <= tree_d;
      lt_q <= lt_d;
      pend_q <= pend_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    sidx_q <= sidx_d; psym_q <= psym_d; hidx_q <= hidx_d; nleaf_q <= nleaf_d;
    top_q <= top_d; j_q <= j_d; pj_q <= pj_d; a_q <= a_d; b_q <= b_d;
    wa_q <= wa_d; wb_q <= wb_d; va_q <= va_d; vb_q <= vb_d;
    dep_q <= dep_d; acc_q <= acc_d; bits_q <= bits_d; len_q <= len_d; st_q <= st_d;
  end

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && ready_o) |=> (state_q != S_IDLE))
    else $error("accepted transaction left sequencer idle");

  a_scan_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> !n_we)
    else $error("node store written during scan");

  a_leaf_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(lt_q) <= Symbols)
    else $error("leaf total out of range");

  a_tree_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WB && int'(top_q) + 1 == 2 * int'(nleaf_q) - 1) |=> tree_q)
    else $error("last merge did not mark tree ready");

endmodule

/* rtl/core/huffman_code_builder.sv */
`timescale 1ns / 1ps
// Channel   Handshake                  Payload
// in        in_valid_i / in_ready_o    action_i, symbol_i
// out       out_valid_o / out_ready_i  status_o, symbol_count_o, code_length_o, code_bits_o
//
// Add does one histogram read and a saturating write-back; clear only drops the valid bits.
// Build: a leaf sweep over the histogram, then for each merge a scan that reads one node store
// entry per cycle over all nodes made so far, followed by the parent and child writes.
// Query: a symbol table lookup, then one node store read per tree level.
// Reset clears histogram valid bits and tree state; no clearing pass.
// A result waits in the output register while the next transaction is taken.

module huffman_code_builder #(
  parameter int Symbols   = hcb_pkg::SymbolsDef,
  parameter int CountBits = hcb_pkg::CountBitsDef,
  parameter int MaxCode   = hcb_pkg::MaxCodeDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [1:0]                   action_i,
  input  logic [6:0]                   symbol_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [1:0]                   status_o,
  output logic [$clog2(Symbols+1)-1:0] symbol_count_o,
  output logic [$clog2(MaxCode+1)-1:0] code_length_o,
  output logic [MaxCode-1:0]           code_bits_o
);
  import hcb_pkg::*;

  localparam int CntW = $clog2(Symbols + 1);
  localparam int LenW = $clog2(MaxCode + 1);

  logic out_valid_q, out_valid_d, out_free, res_valid;
  status_e res_status, status_q;
  logic [CntW-1:0] res_count, count_q;
  logic [LenW-1:0] res_len, len_q;
  logic [MaxCode-1:0] res_bits, bits_q;

  hcb_engine #(.Symbols(Symbols), .CountBits(CountBits), .MaxCode(MaxCode)) u_engine (
    .clk_i, .rst_ni,
    .in_valid_i, .action_i, .symbol_i, .ready_o(in_ready_o),
    .out_free_i(out_free), .res_valid_o(res_valid), .res_status_o(res_status),
    .res_count_o(res_count), .res_len_o(res_len), .res_bits_o(res_bits)
  );

  // output register
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      status_q <= res_status;
      count_q <= res_count;
      len_q <= res_len;
      bits_q <= res_bits;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign symbol_count_o = count_q;
  assign code_length_o  = len_q;
  assign code_bits_o    = bits_q;

endmodule

/* verif/tb_huffman_code_builder.sv */
`timescale 1ns / 1ps

module tb_huffman_code_builder;
  import hcb_pkg::*;

  localparam int NSYM      = 128;
  localparam int NNODE     = 2 * NSYM - 1;
  localparam int CODE_MAX  = 48;
  localparam int IDLE_MAX  = 200000;
  localparam int HOLD_LEN  = 300;
  localparam int ERR_SHOWN = 10;

  typedef struct packed {
    status_e      status;
    logic [7:0]   count;
    logic [5:0]   len;
    logic [47:0]  bits;
  } code_resp_t;

  typedef struct {
    action_e     act;
    logic [6:0]  sym;
    int          reps;
    bit          sweep;
    bit          fixed;
    code_resp_t  want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  logic [1:0] action_i;
  logic [6:0] symbol_i;
  logic out_valid_o;
  logic out_ready_i;
  logic [1:0] status_o;
  logic [7:0] symbol_count_o;
  logic [5:0] code_length_o;
  logic [47:0] code_bits_o;

  huffman_code_builder u_dut (
    .clk_i         (clk),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .action_i      (action_i),
    .symbol_i      (symbol_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .symbol_count_o(symbol_count_o),
    .code_length_o (code_length_o),
    .code_bits_o   (code_bits_o)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 0;
  end

  // Shadow copy of the histogram and code tree
  logic [15:0] hist_q [NSYM];
  logic [23:0] wt_q [NNODE];
  logic [7:0]  up_q [NNODE];
  bit          linked_q [NNODE];
  bit          right_q [NNODE];
  logic [7:0]  leaf_q [NSYM];
  bit          present_q [NSYM];
  logic [7:0]  leaf_cnt_q;
  bit          tree_ok_q;

  code_resp_t resp_q[$];
  int  errors;
  int  checked;
  int  sent;
  int  builds;
  int  idle_cycles;
  bit  calm;
  bit  hold_req;

  function automatic status_e grow_tree();
    int n;
    int top;
    int a;
    int b;
    bit va;
    bit vb;
    n = 0;
    for (int s = 0; s < NSYM; s++) begin
      present_q[s] = 0;
      if (hist_q[s] != 0) begin
        wt_q[n] = 24'(hist_q[s]);
        up_q[n] = 0;
        linked_q[n] = 0;
        right_q[n] = 0;
        leaf_q[s] = 8'(n);
        present_q[s] = 1;
        n++;
      end
    end
    leaf_cnt_q = 8'(n);
    if (n == 0) begin
      tree_ok_q = 0;
      return ST_EMPTY;
    end
    // each merge joins the two lightest free nodes, first found wins ties
    for (int i = 0; i + 1 < n; i++) begin
      top = n + i;
      a = 0; b = 0; va = 0; vb = 0;
      for (int j = 0; j < top; j++) begin
        if (linked_q[j]) continue;
        if (!va || wt_q[j] < wt_q[a]) begin
          b = a; vb = va; a = j; va = 1;
        end else if (!vb || wt_q[j] < wt_q[b]) begin
          b = j; vb = 1;
        end
      end
      wt_q[top] = wt_q[a] + wt_q[b];
      linked_q[top] = 0;
      up_q[top] = 0;
      right_q[top] = 0;
      up_q[a] = 8'(top); linked_q[a] = 1; right_q[a] = 0;
      up_q[b] = 8'(top); linked_q[b] = 1; right_q[b] = 1;
    end
    tree_ok_q = 1;
    return ST_OK;
  endfunction

  function automatic code_resp_t next_resp(action_e act, logic [6:0] sym);
    code_resp_t r;
    logic [NNODE-1:0] path;
    int node;
    int depth;
    int keep;
    r = '0;
    r.status = ST_OK;
    path = '0;
    case (act)
      ACT_ADD: begin
        if (hist_q[sym] != 16'hFFFF) hist_q[sym]++;
      end
      ACT_BUILD: begin
        r.status = grow_tree();
      end
      ACT_QUERY: begin
        if (!tree_ok_q) r.status = ST_NOTREE;
        else if (!present_q[sym]) r.status = ST_ABSENT;
        else begin
          // walk leaf to root, then emit root-first
          node = leaf_q[sym];
          depth = 0;
          while (linked_q[node]) begin
            path[depth] = right_q[node];
            depth++;
            node = up_q[node];
          end
          keep = (depth > CODE_MAX) ? CODE_MAX : depth;
          for (int k = 0; k < keep; k++) r.bits = {r.bits[46:0], path[depth-1-k]};
          r.len = 6'(keep);
        end
      end
      default: begin
        for (int s = 0; s < NSYM; s++) hist_q[s] = 0;
      end
    endcase
    r.count = leaf_cnt_q;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offer one transaction and log its expected response once taken
  task automatic send_item(action_e act, logic [6:0] sym, bit fixed, code_resp_t want);
    int gap;
    code_resp_t r;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid_i <= 1'b1;
    action_i   <= act;
    symbol_i   <= sym;
    do @(posedge clk); while (!in_ready_o);
    r = next_resp(act, sym);
    resp_q.push_back(fixed ? want : r);
    sent++;
    if (act == ACT_BUILD) builds++;
  endtask

  // Response side: random back-pressure and field compare
  initial begin
    int hold;
    int r;
    code_resp_t w;
    out_ready_i = 1'b0;
    hold = 0;
    forever begin
      @(posedge clk);
      if (out_valid_o && out_ready_i) begin
        if (resp_q.size() == 0) begin
          errors++;
          if (errors <= ERR_SHOWN) $display("unexpected response status=%0d", status_o);
        end else begin
          w = resp_q.pop_front();
          checked++;
          if (status_o !== w.status || symbol_count_o !== w.count ||
              code_length_o !== w.len || code_bits_o !== w.bits) begin
            errors++;
            if (errors <= ERR_SHOWN)
              $display("mismatch #%0d: exp st=%0d n=%0d len=%0d bits=%h got st=%0d n=%0d len=%0d bits=%h",
                       checked, w.status, w.count, w.len, w.bits,
                       status_o, symbol_count_o, code_length_o, code_bits_o);
          end
        end
      end
      if (hold_req) begin
        hold_req = 0;
        hold = HOLD_LEN;
      end
      if (hold > 0) begin
        hold--;
        out_ready_i <= 1'b0;
      end else if (calm) begin
        out_ready_i <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 6) hold = $urandom_range(10, 50);
        else if (r < 30) hold = $urandom_range(1, 3);
        out_ready_i <= (hold == 0);
      end
    end
  end

  // Watchdog on lack of progress
  always @(posedge clk) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_MAX) begin
      $display("timeout after %0d idle cycles", idle_cycles);
      $display("tb_huffman_code_builder NOT OK");
      $finish;
    end
  end

  initial begin
    stim_row_t rows[$];
    code_resp_t nil;
    int seqs;
    int pool_base;
    int pool_size;
    int nadd;
    logic [6:0] s;

    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    action_i = ACT_ADD;
    symbol_i = '0;
    errors = 0; checked = 0; sent = 0; builds = 0; idle_cycles = 0;
    calm = 0; hold_req = 0;
    for (int i = 0; i < NSYM; i++) begin
      hist_q[i] = 0; leaf_q[i] = 0; present_q[i] = 0;
    end
    for (int i = 0; i < NNODE; i++) begin
      wt_q[i] = 0; up_q[i] = 0; linked_q[i] = 0; right_q[i] = 0;
    end
    leaf_cnt_q = 0;
    tree_ok_q = 0;
    nil = '0;

    // Directed: fixed rows carry typed responses, the rest use the predictor
    rows = '{
      '{ACT_QUERY, 7'd0,   1, 0, 1, '{ST_NOTREE, 8'd0, 6'd0, 48'd0}},
      '{ACT_BUILD, 7'd0,   1, 0, 1, '{ST_EMPTY,  8'd0, 6'd0, 48'd0}},
      '{ACT_ADD,   7'd127, 1, 0, 1, '{ST_OK,     8'd0, 6'd0, 48'd0}},
      '{ACT_CLEAR, 7'd0,   1, 0, 1, '{ST_OK,     8'd0, 6'd0, 48'd0}},
      '{ACT_BUILD, 7'd0,   1, 0, 1, '{ST_EMPTY,  8'd0, 6'd0, 48'd0}},
      '{ACT_ADD,   7'd9,   1, 0, 1, '{ST_OK,     8'd0, 6'd0, 48'd0}},
      '{ACT_BUILD, 7'd0,   1, 0, 1, '{ST_OK,     8'd1, 6'd0, 48'd0}},
      '{ACT_QUERY, 7'd9,   1, 0, 1, '{ST_OK,     8'd1, 6'd0, 48'd0}},
      '{ACT_QUERY, 7'd127, 1, 0, 1, '{ST_ABSENT, 8'd1, 6'd0, 48'd0}},
      '{ACT_CLEAR, 7'd0,   1, 0, 1, '{ST_OK,     8'd1, 6'd0, 48'd0}},
      '{ACT_QUERY, 7'd9,   1, 0, 1, '{ST_OK,     8'd1, 6'd0, 48'd0}},
      '{ACT_ADD,   7'd5,  40, 0, 0, nil},
      '{ACT_ADD,   7'd127, 1, 0, 0, nil},
      '{ACT_ADD,   7'd0,   2, 0, 0, nil},
      '{ACT_BUILD, 7'd0,   1, 0, 0, nil},
      '{ACT_QUERY, 7'd5,   1, 0, 0, nil},
      '{ACT_QUERY, 7'd127, 1, 0, 0, nil},
      '{ACT_QUERY, 7'd0,   1, 0, 0, nil},
      '{ACT_QUERY, 7'd64,  1, 0, 1, '{ST_ABSENT, 8'd3, 6'd0, 48'd0}},
      '{ACT_ADD,   7'd0, 128, 1, 0, nil},
      '{ACT_BUILD, 7'd0,   1, 0, 0, nil},
      '{ACT_QUERY, 7'd0,   1, 0, 0, nil},
      '{ACT_QUERY, 7'd127, 1, 0, 0, nil},
      '{ACT_QUERY, 7'd5,   1, 0, 0, nil}
    };

    repeat (12) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      calm = (rows[i].reps > 1000);
      for (int k = 0; k < rows[i].reps; k++)
        send_item(rows[i].act, rows[i].sweep ? 7'(rows[i].sym + k) : rows[i].sym,
                  rows[i].fixed, rows[i].want);
    end
    calm = 0;

    // Long response stall while adds keep coming
    hold_req = 1;
    for (int k = 0; k < 20; k++) send_item(ACT_ADD, 7'($urandom_range(0, 127)), 0, nil);

    // Random: count, build, query sequences over small symbol pools or the full alphabet, plus noise
    seqs = 0;
    while (sent < 550) begin
      calm = ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 9) == 0) begin
        send_item(action_e'($urandom_range(0, 3)), 7'($urandom_range(0, 127)), 0, nil);
        continue;
      end
      if ($urandom_range(0, 2) != 0) send_item(ACT_CLEAR, 7'($urandom), 0, nil);
      if (seqs % 12 == 5) begin
        pool_base = 0; pool_size = 128;
      end else begin
        pool_size = $urandom_range(2, 16);
        pool_base = $urandom_range(0, 128 - pool_size);
      end
      nadd = $urandom_range(pool_size, pool_size + 30);
      for (int k = 0; k < nadd; k++) begin
        // skew toward low end of the pool for uneven weights
        s = 7'(pool_base + ($urandom_range(0, pool_size - 1) * $urandom_range(0, 3)) / 3);
        send_item(ACT_ADD, s, 0, nil);
      end
      send_item(ACT_BUILD, 7'($urandom), 0, nil);
      for (int k = $urandom_range(3, 8); k > 0; k--) begin
        if ($urandom_range(0, 3) == 0) s = 7'($urandom_range(0, 127));
        else s = 7'(pool_base + $urandom_range(0, pool_size - 1));
        send_item(ACT_QUERY, s, 0, nil);
      end
      seqs++;
    end
    calm = 0;

    @(posedge clk);
    in_valid_i <= 1'b0;
    while (resp_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);

    $display("ran %0d transactions (%0d tree builds, %0d sequences), %0d responses checked",
             sent, builds, seqs, checked);
    $display("covered empty/single/full alphabets, repeated counts, stale-tree queries");
    if (errors == 0 && resp_q.size() == 0) begin
      $display("tb_huffman_code_builder OK");
    end else begin
      $display("errors: %0d, responses still pending: %0d", errors, resp_q.size());
      $display("tb_huffman_code_builder NOT OK");
    end
    $finish;
  end

endmodule

/* huffman_code_builder.f */
rtl/core/hcb_pkg.sv
rtl/core/hcb_ram.sv
rtl/core/hcb_engine.sv
rtl/core/huffman_code_builder.sv
verif/tb_huffman_code_builder.sv
